// File: rtl/core/sct_pkg.sv
`timescale 1ns / 1ps

package sct_pkg;

  localparam int NUM_SEMS  = 16;
  localparam int NUM_PROCS = 16;
  localparam int PID_BITS  = 8;

  localparam int SEM_W   = $clog2(NUM_SEMS);
  localparam int SLOT_W  = $clog2(NUM_PROCS);
  localparam int RING_AW = SEM_W + SLOT_W;

  localparam int OP_W    = 2;
  localparam int ID_W    = 4;
  localparam int COUNT_W = 16;
  localparam int PID_W   = 8;

  localparam logic signed [COUNT_W-1:0] COUNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};
  localparam logic signed [COUNT_W-1:0] COUNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_WAIT   = 2'd1,
    OP_SIGNAL = 2'd2
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic             found;
    logic [SEM_W-1:0] idx;
  } alloc_t;

endpackage

// File: rtl/core/sct_cmd_if.sv
`timescale 1ns / 1ps

interface sct_cmd_if;
  import sct_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic [ID_W-1:0]           sem_id;
  logic signed [COUNT_W-1:0] init_value;
  logic [PID_W-1:0]          caller_pid;

  modport source (output valid, op, sem_id, init_value, caller_pid, input ready);
  modport sink (input valid, op, sem_id, init_value, caller_pid, output ready);
endinterface

// File: rtl/core/sct_rsp_if.sv
`timescale 1ns / 1ps

interface sct_rsp_if;
  import sct_pkg::*;

  logic             valid;
  logic             ready;
  logic             status;
  logic [ID_W-1:0]  alloc_id;
  logic             block_caller;
  logic             wake_valid;
  logic [PID_W-1:0] wake_pid;

  modport source (output valid, status, alloc_id, block_caller, wake_valid, wake_pid,
                  input ready);
  modport sink (input valid, status, alloc_id, block_caller, wake_valid, wake_pid,
                output ready);
endinterface

// File: rtl/core/sct_ram.sv
`timescale 1ns / 1ps

module sct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: rtl/core/sct_alloc.sv
`timescale 1ns / 1ps

module sct_alloc (
  input  logic [sct_pkg::NUM_SEMS-1:0] entry_valid,
  output sct_pkg::alloc_t              alloc
);
  import sct_pkg::*;

  // lowest free entry wins
  always_comb begin
    alloc.found = 1'b0;
    alloc.idx   = '0;
    for (int i = NUM_SEMS - 1; i >= 0; i--) begin
      if (!entry_valid[i]) begin
        alloc.found = 1'b1;
        alloc.idx   = SEM_W'(i);
      end
    end
  end
endmodule

// File: rtl/core/counting_semaphore_table_unit.sv
`timescale 1ns / 1ps

// Counting semaphore table with a FIFO ring of waiting process ids per entry.
// cmd (sink): op, sem_id, init_value, caller_pid. Allocate claims the lowest
//   free entry, wait decrements a count and may queue the caller, signal
//   increments a count and may pop the oldest waiter.
// rsp (source): status, alloc_id, block_caller, wake_valid, wake_pid; exactly
//   one response transaction per command transaction, in order.
// A command accepted at an edge reads the count and ring memories at that
//   edge, executes in the following cycle (ST_EXEC) and has its response
//   registered when ST_EXEC completes, which a stalled older response delays.
// Commands are taken one at a time: cmd.ready stays low until the
//   read-modify-write of the single-port-write count and ring memories is done.
// The next command is accepted while a finished response still waits; if the
//   receiver stalls, that command stays in execution until rsp drains, and
//   cmd.ready stays low meanwhile.
// Reset (synchronous rst) frees all entries and empties all rings; no
//   clearing pass is needed. Counts and ring slots are undefined until
//   written.
module counting_semaphore_table_unit (
  input  logic      clk,
  input  logic      rst,
  sct_cmd_if.sink   cmd,
  sct_rsp_if.source rsp
);
  import sct_pkg::*;

  state_t state, state_next;

  logic [NUM_SEMS-1:0] entry_valid;
  logic [SLOT_W-1:0]   ring_head [NUM_SEMS];
  logic [SLOT_W-1:0]   ring_tail [NUM_SEMS];

  logic [OP_W-1:0]           cur_op;
  logic [SEM_W-1:0]          cur_sem;
  logic                      cur_in_range;
  logic signed [COUNT_W-1:0] cur_init;
  logic [PID_BITS-1:0]       cur_pid;

  logic             out_valid;
  logic             out_status;
  logic [ID_W-1:0]  out_alloc_id;
  logic             out_block;
  logic             out_wake_valid;
  logic [PID_W-1:0] out_wake_pid;

  logic accept, done, rd_en;
  logic [SEM_W-1:0] in_sem;

  alloc_t alloc;

  logic                      cnt_we;
  logic [SEM_W-1:0]          cnt_waddr;
  logic signed [COUNT_W-1:0] cnt_wdata;
  logic signed [COUNT_W-1:0] cnt_rdata;
  logic                      ring_we;
  logic [RING_AW-1:0]        ring_waddr;
  logic [RING_AW-1:0]        ring_raddr;
  logic [PID_BITS-1:0]       ring_rdata;

  logic signed [COUNT_W-1:0] cnt_dec, cnt_inc;
  logic is_alloc, is_wait, is_signal, do_block, do_wake;
  logic n_status, n_block, n_wake_valid;
  logic [ID_W-1:0]  n_alloc_id;
  logic [PID_W-1:0] n_wake_pid;

  assign in_sem = SEM_W'(cmd.sem_id);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid || rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.ready = 1'b0;
    done      = 1'b0;
    unique case (state)
      ST_IDLE: cmd.ready = 1'b1;
      ST_EXEC: done = !out_valid || rsp.ready;
      default: ;
    endcase
  end

  assign accept = cmd.valid && cmd.ready;
  assign rd_en  = accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_op       <= cmd.op;
      cur_sem      <= in_sem;
      cur_in_range <= 32'(cmd.sem_id) < NUM_SEMS;
      cur_init     <= cmd.init_value;
      cur_pid      <= PID_BITS'(cmd.caller_pid);
    end
  end

  sct_alloc u_alloc (
    .entry_valid (entry_valid),
    .alloc       (alloc)
  );

  sct_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (NUM_SEMS)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (rd_en),
    .raddr (in_sem),
    .rdata (cnt_rdata)
  );

  sct_ram #(
    .WIDTH (PID_BITS),
    .DEPTH (NUM_SEMS * NUM_PROCS)
  ) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (cur_pid),
    .re    (rd_en),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  assign ring_raddr = {in_sem, ring_head[in_sem]};
  assign ring_waddr = {cur_sem, ring_tail[cur_sem]};

  always_comb begin
    is_alloc  = cur_op == OP_ALLOC;
    is_wait   = (cur_op == OP_WAIT) && cur_in_range;
    is_signal = (cur_op == OP_SIGNAL) && cur_in_range;

    cnt_dec = (cnt_rdata == COUNT_MIN) ? cnt_rdata : cnt_rdata - COUNT_W'(1);
    cnt_inc = (cnt_rdata == COUNT_MAX) ? cnt_rdata : cnt_rdata + COUNT_W'(1);

    do_block = is_wait && cnt_dec[COUNT_W-1];
    do_wake  = is_signal && (cnt_inc[COUNT_W-1] || cnt_inc == '0);

    cnt_we    = done && ((is_alloc && alloc.found) || is_wait || is_signal);
    cnt_waddr = is_alloc ? alloc.idx : cur_sem;
    cnt_wdata = is_alloc ? cur_init : (is_wait ? cnt_dec : cnt_inc);
    ring_we   = done && do_block;

    n_status     = is_alloc && !alloc.found;
    n_alloc_id   = (is_alloc && alloc.found) ? ID_W'(alloc.idx) : '0;
    n_block      = do_block;
    n_wake_valid = do_wake;
    n_wake_pid   = do_wake ? PID_W'(ring_rdata) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      for (int i = 0; i < NUM_SEMS; i++) begin
        ring_head[i] <= '0;
        ring_tail[i] <= '0;
      end
    end else if (done) begin
      if (is_alloc && alloc.found) begin
        entry_valid[alloc.idx] <= 1'b1;
      end
      if (do_block) begin
        ring_tail[cur_sem] <= ring_tail[cur_sem] + SLOT_W'(1);
      end
      if (do_wake) begin
        ring_head[cur_sem] <= ring_head[cur_sem] + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_status     <= n_status;
      out_alloc_id   <= n_alloc_id;
      out_block      <= n_block;
      out_wake_valid <= n_wake_valid;
      out_wake_pid   <= n_wake_pid;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.alloc_id     = out_alloc_id;
  assign rsp.block_caller = out_block;
  assign rsp.wake_valid   = out_wake_valid;
  assign rsp.wake_pid     = out_wake_pid;
endmodule
